// ----- sv/pdfk_pkg.sv -----
package pdfk_pkg;

   // Receive phases of the deframer.
   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN_LO = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC_LO = 3'd4,
      PH_CRC_HI = 3'd5
   } phase_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_BUSY    = 3'd1,
      ST_OK      = 3'd2,
      ST_NODELIM = 3'd3,
      ST_SIZE    = 3'd4,
      ST_CRC     = 3'd5
   } status_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DELIMITER   = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd1;
   localparam logic [1:0] CSR_CRC_ENABLE  = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // Reflected CRC-16/KERMIT polynomial.
   localparam logic [15:0] KERMIT_POLY = 16'h8408;

   // Reset values of the configuration registers.
   localparam logic [7:0]  DELIMITER_RST   = 8'd0;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd65530;
   localparam logic        CRC_ENABLE_RST  = 1'b1;

   // Configuration as seen by the frame logic.
   typedef struct packed {
      logic [7:0]  delimiter;
      logic [15:0] max_payload;
      logic        crc_enable;
   } cfg_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
   } result_type;

   // One byte through the reflected CRC, one bit per step.
   function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ KERMIT_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/pdfk_if.sv -----
// Input channel: one received byte per transfer.
interface pdfk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel: one result per transfer.
interface pdfk_rsp_if;
   logic                  valid;
   logic                  ready;
   pdfk_pkg::status_type  status;
   logic                  data_valid;
   logic [7:0]            data_byte;
   logic [15:0]           payload_index;
   logic [15:0]           frame_length;

   modport source (output valid, output status, output data_valid, output data_byte,
                   output payload_index, output frame_length, input ready);
   modport sink (input valid, input status, input data_valid, input data_byte,
                 input payload_index, input frame_length, output ready);
endinterface

// ----- sv/pdfk_frame.sv -----
// Frame state machine and CRC accumulator. Works out the result for the byte
// presented and advances the frame state when step is high.
module pdfk_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  pdfk_pkg::cfg_type    cfg,
   output pdfk_pkg::result_type result
);

   pdfk_pkg::phase_type phase_ff, phase_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic [15:0] full_len;
   logic [15:0] count_inc;
   logic        too_long;
   logic        done_payload;
   logic        crc_match;

   // Shared decisions for both the next state and the outputs.
   assign full_len  = {rx_byte, size_ff[7:0]};
   assign count_inc = count_ff + 16'd1;
   assign too_long  = full_len > cfg.max_payload;
   assign crc_match = {rx_byte, crc_low_ff} == crc_ff;

   always_comb begin
      case (phase_ff)
         pdfk_pkg::PH_LEN_HI: done_payload = !too_long && (full_len == 16'd0);
         pdfk_pkg::PH_DATA:   done_payload = count_inc >= size_ff;
         default:             done_payload = 1'b0;
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         pdfk_pkg::PH_LEN_LO: phase_in = pdfk_pkg::PH_LEN_HI;
         pdfk_pkg::PH_LEN_HI: phase_in = too_long ? pdfk_pkg::PH_HUNT : pdfk_pkg::PH_DATA;
         pdfk_pkg::PH_DATA:   phase_in = pdfk_pkg::PH_DATA;
         pdfk_pkg::PH_CRC_LO: phase_in = pdfk_pkg::PH_CRC_HI;
         pdfk_pkg::PH_CRC_HI: phase_in = pdfk_pkg::PH_HUNT;
         default: begin
            phase_in = (rx_byte == cfg.delimiter) ? pdfk_pkg::PH_LEN_LO : pdfk_pkg::PH_HUNT;
         end
      endcase
      if (done_payload) begin
         phase_in = cfg.crc_enable ? pdfk_pkg::PH_CRC_LO : pdfk_pkg::PH_HUNT;
      end
   end

   // Datapath registers and result fields.
   always_comb begin
      size_in              = size_ff;
      count_in             = count_ff;
      crc_in               = crc_ff;
      crc_low_in           = crc_low_ff;
      result.status        = pdfk_pkg::ST_NONE;
      result.data_valid    = 1'b0;
      result.data_byte     = 8'd0;
      result.payload_index = 16'd0;
      result.frame_length  = 16'd0;
      unique case (phase_ff)
         pdfk_pkg::PH_LEN_LO: begin
            size_in       = {8'd0, rx_byte};
            result.status = pdfk_pkg::ST_BUSY;
         end
         pdfk_pkg::PH_LEN_HI: begin
            if (too_long) begin
               size_in       = 16'd0;
               result.status = pdfk_pkg::ST_SIZE;
            end else begin
               size_in       = full_len;
               count_in      = 16'd0;
               crc_in        = 16'd0;
               result.status = pdfk_pkg::ST_BUSY;
            end
         end
         pdfk_pkg::PH_DATA: begin
            result.data_valid    = 1'b1;
            result.data_byte     = rx_byte;
            result.payload_index = count_ff;
            crc_in               = pdfk_pkg::kermit_update(crc_ff, rx_byte);
            count_in             = count_inc;
            result.status        = pdfk_pkg::ST_BUSY;
         end
         pdfk_pkg::PH_CRC_LO: begin
            crc_low_in    = rx_byte;
            result.status = pdfk_pkg::ST_BUSY;
         end
         pdfk_pkg::PH_CRC_HI: begin
            if (crc_match) begin
               result.status       = pdfk_pkg::ST_OK;
               result.frame_length = size_ff;
            end else begin
               result.status = pdfk_pkg::ST_CRC;
               size_in       = 16'd0;
            end
         end
         default: begin
            result.status = (rx_byte == cfg.delimiter) ? pdfk_pkg::ST_BUSY
                                                       : pdfk_pkg::ST_NODELIM;
         end
      endcase
      // End of payload: either wait for the CRC or finish here.
      if (done_payload) begin
         if (cfg.crc_enable) begin
            result.status = pdfk_pkg::ST_BUSY;
         end else begin
            result.status       = pdfk_pkg::ST_OK;
            result.frame_length = size_in;
         end
      end
   end

   // State registers, advanced once per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pdfk_pkg::PH_HUNT;
         size_ff    <= 16'd0;
         count_ff   <= 16'd0;
         crc_ff     <= 16'd0;
         crc_low_ff <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         size_ff    <= size_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

// ----- sv/packet_deframer_crc16_kermit.sv -----
// Receives a byte stream, one byte per transfer, and returns exactly one result
// per byte. A frame is the delimiter byte, a 16-bit little-endian payload
// length, the payload and, when crc_enable is set, a CRC-16/KERMIT over the
// payload, low byte first. Payload bytes come out with data_valid and their
// index; the consumer should keep them until a success status arrives, since
// a size or CRC failure discards the frame. The block takes one byte every
// clock cycle when the result side keeps up; each byte is first held in the
// input register while the byte-wide CRC update and state step work out its
// result, which is then loaded into the result register that drives the
// outputs once that register is empty or drained.
// Configuration writes should be made while no bytes are in flight.
module packet_deframer_crc16_kermit (
   input  logic                                clock,
   input  logic                                reset,
   pdfk_req_if.sink                            req_chan,
   pdfk_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [pdfk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pdfk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pdfk_pkg::cfg_type    cfg_ff;
   pdfk_pkg::result_type result;
   pdfk_pkg::result_type rsp_ff;

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_vld_ff;
   logic       advance;
   logic       step;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter   <= pdfk_pkg::DELIMITER_RST;
         cfg_ff.max_payload <= pdfk_pkg::MAX_PAYLOAD_RST;
         cfg_ff.crc_enable  <= pdfk_pkg::CRC_ENABLE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pdfk_pkg::CSR_DELIMITER:   cfg_ff.delimiter   <= csr_wdata[7:0];
            pdfk_pkg::CSR_MAX_PAYLOAD: cfg_ff.max_payload <= csr_wdata[15:0];
            pdfk_pkg::CSR_CRC_ENABLE:  cfg_ff.crc_enable  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the result register takes a new value when empty or drained.
   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign step           = in_vld_ff && advance;
   assign req_chan.ready = !in_vld_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   pdfk_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.data_valid    = rsp_ff.data_valid;
   assign rsp_chan.data_byte     = rsp_ff.data_byte;
   assign rsp_chan.payload_index = rsp_ff.payload_index;
   assign rsp_chan.frame_length  = rsp_ff.frame_length;

endmodule

// ----- tb/pdfk_tb_pkg.sv -----
`timescale 1ns / 100ps
package pdfk_tb_pkg;

   import pdfk_pkg::*;

   // Register index that lies beyond the implemented registers; writes to it are dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // Advances a reflected CRC-16/KERMIT by one byte, taking the data bits LSB first.
   function automatic logic [15:0] crc16_kermit_byte(input logic [15:0] crc,
                                                      input logic [7:0] value);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[0] ^ value[i];
         acc = {1'b0, acc[15:1]};
         if (feedback) begin
            acc = acc ^ KERMIT_POLY;
         end
      end
      return acc;
   endfunction

endpackage

// ----- tb/pdfk_frame_checker.sv -----
`timescale 1ns / 100ps
module pdfk_frame_checker
   import pdfk_pkg::*;
   import pdfk_tb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pdfk_req_if                    req_mon,
   pdfk_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            fault_count,
   output int unsigned            pending_results
);

   // Shadow copy of the configuration registers.
   logic [7:0]  cfg_delim;
   logic [15:0] cfg_max;
   logic        cfg_crc_on;

   // Shadow copy of the deframer state.
   phase_type   rx_phase;
   logic [15:0] frame_len;
   logic [15:0] byte_idx;
   logic [15:0] crc_run;
   logic [7:0]  crc_lo_byte;

   result_type  expected_results[$];
   result_type  seen;
   result_type  want;
   int unsigned faults;

   // Steps the shadow deframer by one received byte and returns the result it should give.
   function automatic result_type deframe_byte(input logic [7:0] value);
      result_type res;
      logic       payload_done;
      res = '0;
      res.status = ST_NONE;
      payload_done = 1'b0;
      case (rx_phase)
         PH_LEN_LO: begin
            frame_len = {8'd0, value};
            rx_phase = PH_LEN_HI;
            res.status = ST_BUSY;
         end
         PH_LEN_HI: begin
            frame_len = {value, frame_len[7:0]};
            if (frame_len > cfg_max) begin
               frame_len = '0;
               rx_phase = PH_HUNT;
               res.status = ST_SIZE;
            end else begin
               byte_idx = '0;
               crc_run = '0;
               if (frame_len == 16'd0) begin
                  payload_done = 1'b1;
               end else begin
                  rx_phase = PH_DATA;
                  res.status = ST_BUSY;
               end
            end
         end
         PH_DATA: begin
            res.data_valid = 1'b1;
            res.data_byte = value;
            res.payload_index = byte_idx;
            crc_run = crc16_kermit_byte(crc_run, value);
            byte_idx = byte_idx + 16'd1;
            if (byte_idx >= frame_len) begin
               payload_done = 1'b1;
            end else begin
               res.status = ST_BUSY;
            end
         end
         PH_CRC_LO: begin
            crc_lo_byte = value;
            rx_phase = PH_CRC_HI;
            res.status = ST_BUSY;
         end
         PH_CRC_HI: begin
            if ({value, crc_lo_byte} == crc_run) begin
               res.status = ST_OK;
               res.frame_length = frame_len;
            end else begin
               res.status = ST_CRC;
               frame_len = '0;
            end
            rx_phase = PH_HUNT;
         end
         default: begin
            if (value == cfg_delim) begin
               rx_phase = PH_LEN_LO;
               res.status = ST_BUSY;
            end else begin
               rx_phase = PH_HUNT;
               res.status = ST_NODELIM;
            end
         end
      endcase
      // The CRC setting is taken at the moment the payload completes.
      if (payload_done) begin
         if (cfg_crc_on) begin
            rx_phase = PH_CRC_LO;
            res.status = ST_BUSY;
         end else begin
            rx_phase = PH_HUNT;
            res.status = ST_OK;
            res.frame_length = frame_len;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_delim = DELIMITER_RST;
         cfg_max = MAX_PAYLOAD_RST;
         cfg_crc_on = CRC_ENABLE_RST;
         rx_phase = PH_HUNT;
         frame_len = '0;
         byte_idx = '0;
         crc_run = '0;
         crc_lo_byte = '0;
         expected_results.delete();
         faults = 0;
      end else begin
         // Register writes reach the shadow configuration straight away.
         if (csr_we) begin
            case (csr_index)
               CSR_DELIMITER:   cfg_delim = csr_wdata[7:0];
               CSR_MAX_PAYLOAD: cfg_max = csr_wdata[15:0];
               CSR_CRC_ENABLE:  cfg_crc_on = csr_wdata[0];
               default: ;
            endcase
         end

         // Each result transfer is held against the oldest outstanding prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status = rsp_mon.status;
            seen.data_valid = rsp_mon.data_valid;
            seen.data_byte = rsp_mon.data_byte;
            seen.payload_index = rsp_mon.payload_index;
            seen.frame_length = rsp_mon.frame_length;
            if (expected_results.size() == 0) begin
               if (faults < 10) begin
                  $display("%0t: unexpected result status %0d valid %0d byte %02h",
                           $realtime, seen.status, seen.data_valid, seen.data_byte,
                           " index %0d length %0d", seen.payload_index, seen.frame_length);
               end
               faults++;
            end else begin
               want = expected_results.pop_front();
               if (seen.status !== want.status || seen.data_valid !== want.data_valid ||
                   seen.data_byte !== want.data_byte ||
                   seen.payload_index !== want.payload_index ||
                   seen.frame_length !== want.frame_length) begin
                  if (faults < 10) begin
                     $display("%0t: expected status %0d valid %0d byte %02h",
                              $realtime, want.status, want.data_valid, want.data_byte,
                              " index %0d length %0d", want.payload_index,
                              want.frame_length);
                     $display("%0t: actual   status %0d valid %0d byte %02h",
                              $realtime, seen.status, seen.data_valid, seen.data_byte,
                              " index %0d length %0d", seen.payload_index,
                              seen.frame_length);
                  end
                  faults++;
               end
            end
         end

         // Every byte transfer predicts exactly one result.
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(deframe_byte(req_mon.rx_byte));
         end
      end
      fault_count <= faults;
      pending_results <= expected_results.size();
   end

endmodule

// ----- tb/tb_packet_deframer_crc16_kermit.sv -----
`timescale 1ns / 100ps
module tb_packet_deframer_crc16_kermit;

   import pdfk_pkg::*;
   import pdfk_tb_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam int unsigned PHASE_BYTES     = 175;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 6;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            fault_count;
   int unsigned            pending_results;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          hold_request;
   int unsigned bytes_sent;

   // The stimulus keeps its own note of the settings in force, to build frames.
   logic [7:0]  cur_delim;
   logic [15:0] cur_max;
   logic        cur_crc_on;

   pdfk_req_if req_bus ();
   pdfk_rsp_if rsp_bus ();

   packet_deframer_crc16_kermit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pdfk_frame_checker frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fault_count     (fault_count),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result side: random back-pressure, plus one long hold-off when asked for.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one byte, with random gaps first, and returns at the falling edge after its transfer.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sends a whole frame with random payload; the CRC is spoilt when asked.
   task automatic send_frame(input logic [15:0] len, input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  value;
      crc = '0;
      send_byte(cur_delim);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      for (int i = 0; i < int'(len); i++) begin
         value = $urandom_range(255);
         crc = crc16_kermit_byte(crc, value);
         send_byte(value);
      end
      if (corrupt) begin
         crc = crc ^ 16'($urandom_range(65535, 1));
      end
      if (cur_crc_on) begin
         send_byte(crc[7:0]);
         send_byte(crc[15:8]);
      end
   endtask

   // Stops offering and waits until every predicted result has come out.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sets up the registers and the idling pattern for the next phase.
   task automatic configure(input logic [7:0] delim, input logic [15:0] max_len,
                            input logic crc_on, input idle_mode_type mode);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_DELIMITER;
      csr_wdata <= {8'd0, delim};
      @(negedge clock);
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= max_len;
      @(negedge clock);
      csr_index <= CSR_CRC_ENABLE;
      csr_wdata <= {15'd0, crc_on};
      @(negedge clock);
      // A write to an index beyond the register list must change nothing.
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom_range(65535));
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      cur_delim = delim;
      cur_max = max_len;
      cur_crc_on = crc_on;
      case (mode)
         IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0; end
         IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 82; end
         IDLE_BOTH: begin send_idle_pct = 17; recv_stall_pct = 17; end
         default:   begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
   endtask

   // Mostly well-formed frames, with stray bytes, oversized lengths and bad CRCs mixed in.
   task automatic random_traffic(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned burst;
      logic [15:0] len;
      logic [7:0]  value;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            burst = $urandom_range(3, 1);
            repeat (burst) begin
               value = $urandom_range(255);
               if (value == cur_delim) begin
                  value = ~value;
               end
               send_byte(value);
            end
         end else if (pick < 20 && cur_max != 16'hFFFF) begin
            len = 16'($urandom_range(65535, int'(cur_max) + 1));
            send_byte(cur_delim);
            send_byte(len[7:0]);
            send_byte(len[15:8]);
         end else begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               len = '0;
            end else if (pick < 90) begin
               len = 16'($urandom_range(12, 1));
            end else begin
               len = 16'($urandom_range(48, 13));
            end
            if (len > cur_max) begin
               len = cur_max;
            end
            send_frame(len, $urandom_range(99) < 15);
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      logic [15:0] crc;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      hold_request = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      bytes_sent = 0;
      cur_delim = DELIMITER_RST;
      cur_max = MAX_PAYLOAD_RST;
      cur_crc_on = CRC_ENABLE_RST;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset settings. Stray bytes while hunting come first.
      send_byte(8'hFF);
      send_byte(8'h55);
      // A zero-length frame: the CRC of nothing is zero.
      send_byte(cur_delim);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      // The largest length, which is above the limit.
      send_byte(cur_delim);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // The delimiter value inside the payload is plain data.
      crc = crc16_kermit_byte(crc16_kermit_byte(16'd0, cur_delim), 8'hFF);
      send_byte(cur_delim);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(cur_delim);
      send_byte(8'hFF);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      // One payload byte followed by a wrong CRC.
      crc = crc16_kermit_byte(16'd0, 8'hA5) ^ 16'h0001;
      send_byte(cur_delim);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);

      // Random phases over a spread of settings, the extremes among them.
      configure(8'h7E, 16'hFFFF, 1'b1, IDLE_NONE);
      hold_request = 1'b1;
      random_traffic(PHASE_BYTES);
      configure(8'hFF, 16'd0, 1'b1, IDLE_SEND);
      random_traffic(PHASE_BYTES);
      configure(8'h00, MAX_PAYLOAD_RST, 1'b0, IDLE_RECV);
      random_traffic(PHASE_BYTES);
      configure(8'($urandom_range(255)), 16'($urandom_range(20, 1)), 1'b0, IDLE_BOTH);
      random_traffic(PHASE_BYTES);
      configure(8'($urandom_range(255)), 16'($urandom_range(40)), 1'b1, IDLE_NONE);
      random_traffic(PHASE_BYTES);
      configure(8'h7E, 16'd8, 1'b1, IDLE_BOTH);
      random_traffic(PHASE_BYTES);
      configure(8'($urandom_range(255)), 16'hFFFF, 1'b0, IDLE_SEND);
      random_traffic(PHASE_BYTES);
      configure(8'($urandom_range(255)), 16'($urandom_range(64)), 1'($urandom_range(1)),
                IDLE_RECV);
      random_traffic(PHASE_BYTES);

      drain();
      if (fault_count == 0 && pending_results == 0) begin
         $display("packet_deframer_crc16_kermit: match");
      end else begin
         $display("packet_deframer_crc16_kermit: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("packet_deframer_crc16_kermit: mismatch");
      $finish;
   end

endmodule
